// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication that stays active through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/stci_pkg.sv =====
// ----------------------------------------------------------------------------
// stci_pkg
// Constants shared by the interpolated sine core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package stci_pkg;

    // Output format: Q1.15 with symmetric saturation.
    localparam int OUT_BITS = 16;
    localparam int OUT_FRAC = 15;
    localparam logic signed [OUT_BITS-1:0] Q15_MAX = 16'sd32767;

    // Width of the interpolation fraction.
    localparam int FRAC_BITS = 16;

    // Fixed-point constants for building the sine table in Q30.
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] Q30_ONE      = 64'h0000_0000_4000_0000;
    localparam logic [63:0] Q30_HALF     = 64'h0000_0000_2000_0000;
    localparam int          TAYLOR_TERMS = 12;

endpackage

`default_nettype wire

// ===== hw/rtl/sine_table_cubic_interp_core.sv =====
// ----------------------------------------------------------------------------
// sine_table_cubic_interp_core
// Phase-to-sine converter: a banked sine ROM and a Catmull-Rom cubic blend.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------
//  phase   | in        | i_valid / o_ready  | i_phase_turn  (PHASE_BITS, uns)
//  sine    | out       | o_valid / i_ready  | o_sine_value  (16, signed Q1.15)
//
//  One request per cycle through six register stages while the output is not
//  stalled; o_valid is the valid bit of the last stage.
//  Stage 1 reads four ROM banks, stages 3 to 5 each hold one multiplier.
//  Each stage holds its own valid bit and advances when the next one is free,
//  so a stalled output still lets requests fill empty stages behind it.
//  Reset clears only the valid bits; the ROM is constant and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_table_cubic_interp_core #(
    parameter int TABLE_BITS  = 12,
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [PHASE_BITS-1:0]                 i_phase_turn,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [stci_pkg::OUT_BITS-1:0]       o_sine_value
);

    import stci_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int ROM_DEPTH  = TABLE_SIZE + 3;
    localparam int QUARTER    = TABLE_SIZE / 4;
    localparam int BANK_DEPTH = QUARTER + 1;
    localparam int FBITS      = PHASE_BITS - TABLE_BITS;
    localparam int AW         = SAMPLE_BITS + 6;
    localparam int PW         = AW + FRAC_BITS + 1;
    localparam int SW         = AW + 5;
    localparam int SHIFT      = SAMPLE_BITS - OUT_FRAC;
    localparam int NSTG       = 6;

    typedef logic signed [SAMPLE_BITS-1:0] t_bank [BANK_DEPTH];

    // Sample of table index j, from a Taylor series in Q30 folded to one quadrant.
    function automatic logic signed [SAMPLE_BITS-1:0] make_sample(
        input logic [TABLE_BITS-1:0] j
    );
        logic [1:0]         q;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic [63:0]        s;
        logic [63:0]        v;
        logic [63:0]        maxv;
        logic signed [63:0] sum;
        logic signed [63:0] sv;
        q    = j[TABLE_BITS-1 -: 2];
        r    = 64'(j[TABLE_BITS-3:0]);
        if (q[0]) begin
            r = 64'(QUARTER) - r;
        end
        x    = (HALF_PI_Q30 * r + 64'(QUARTER / 2)) >> (TABLE_BITS - 2);
        x2   = (x * x + Q30_HALF) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            prod = (term * x2 + Q30_HALF) >> 30;
            unique case (n)
                1:       term = (prod + 64'd3) / 64'd6;
                2:       term = (prod + 64'd10) / 64'd20;
                3:       term = (prod + 64'd21) / 64'd42;
                4:       term = (prod + 64'd36) / 64'd72;
                5:       term = (prod + 64'd55) / 64'd110;
                6:       term = (prod + 64'd78) / 64'd156;
                7:       term = (prod + 64'd105) / 64'd210;
                8:       term = (prod + 64'd136) / 64'd272;
                9:       term = (prod + 64'd171) / 64'd342;
                10:      term = (prod + 64'd210) / 64'd420;
                11:      term = (prod + 64'd253) / 64'd506;
                default: term = 64'd0;
            endcase
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        s = $unsigned(sum);
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        maxv = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        v    = ((s << (SAMPLE_BITS - 1)) + Q30_HALF) >> 30;
        if (v > maxv) begin
            v = maxv;
        end
        sv = q[1] ? -$signed(v) : $signed(v);
        return sv[SAMPLE_BITS-1:0];
    endfunction

    // Bank b holds ROM entries 4a+b. Entry k is the sample of index k-1, wrapped.
    function automatic t_bank build_bank(input int b);
        t_bank bank;
        int    k;
        for (int a = 0; a < BANK_DEPTH; a++) begin
            k = 4 * a + b;
            if (k < ROM_DEPTH) begin
                bank[a] = make_sample(TABLE_BITS'(k + TABLE_SIZE - 1));
            end else begin
                bank[a] = '0;
            end
        end
        return bank;
    endfunction

    logic [NSTG-1:0]        r_vld;
    logic [NSTG-1:0]        stg_en;

    logic [TABLE_BITS-1:0]  n_seg;
    logic [FRAC_BITS-1:0]   n_frac;

    // Stage 1: ROM read.
    logic signed [SAMPLE_BITS-1:0] s1_ybank [4];
    logic [1:0]                    r_s1_rot;
    logic [FRAC_BITS-1:0]          r_s1_f;

    // Stage 2: coefficients.
    logic signed [SAMPLE_BITS-1:0] n_y0, n_y1, n_y2, n_y3;
    logic signed [AW-1:0]          n_e0, n_e1, n_e2, n_e3;
    logic signed [AW-1:0]          r_s2_y1, r_s2_c1, r_s2_c2, r_s2_c3;
    logic [FRAC_BITS-1:0]          r_s2_f;

    // Stages 3 to 5: Horner steps.
    logic signed [PW-1:0]          n_p3, n_p4, n_p5;
    logic signed [AW-1:0]          r_s3_y1, r_s3_c1, r_s3_acc;
    logic [FRAC_BITS-1:0]          r_s3_f;
    logic signed [AW-1:0]          r_s4_y1, r_s4_acc;
    logic [FRAC_BITS-1:0]          r_s4_f;
    logic signed [AW-1:0]          n_acc5;
    logic signed [AW-1:0]          r_s5_total;

    // Stage 6: rescale and saturate.
    logic signed [SW-1:0]          n_ext;
    logic signed [SW-1:0]          n_wide;
    logic signed [OUT_BITS-1:0]    n_out;
    logic signed [OUT_BITS-1:0]    r_s6_out;

    localparam logic signed [SW-1:0] SAT_HI = SW'(Q15_MAX);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI;

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            stg_en[s] = !r_vld[s] || stg_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (stg_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_ready      = stg_en[0];
    assign o_valid      = r_vld[NSTG-1];
    assign o_sine_value = r_s6_out;

    // ------------------------------------------------------------------
    // Phase split
    // ------------------------------------------------------------------
    assign n_seg = i_phase_turn[PHASE_BITS-1 -: TABLE_BITS];

    generate
        if (FBITS >= FRAC_BITS) begin : g_frac_trunc
            assign n_frac = i_phase_turn[FBITS-1 -: FRAC_BITS];
        end else begin : g_frac_pad
            assign n_frac = {i_phase_turn[FBITS-1:0], (FRAC_BITS - FBITS)'(0)};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 1: the four neighbors seg..seg+3 fall in four different banks.
    // ------------------------------------------------------------------
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam t_bank BANK = build_bank(gb);
        logic [1:0]                    n_off;
        logic [TABLE_BITS:0]           n_k;
        logic signed [SAMPLE_BITS-1:0] r_rd;

        assign n_off = 2'(gb) - n_seg[1:0];
        assign n_k   = {1'b0, n_seg} + {{(TABLE_BITS - 1){1'b0}}, n_off};

        always_ff @(posedge i_clk) begin
            if (stg_en[0]) begin
                r_rd <= BANK[n_k[TABLE_BITS:2]];
            end
        end

        assign s1_ybank[gb] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_rot <= n_seg[1:0];
            r_s1_f   <= n_frac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: undo the bank rotation, form doubled Catmull-Rom coefficients.
    // ------------------------------------------------------------------
    always_comb begin
        unique case (r_s1_rot)
            2'd0: begin
                n_y0 = s1_ybank[0]; n_y1 = s1_ybank[1];
                n_y2 = s1_ybank[2]; n_y3 = s1_ybank[3];
            end
            2'd1: begin
                n_y0 = s1_ybank[1]; n_y1 = s1_ybank[2];
                n_y2 = s1_ybank[3]; n_y3 = s1_ybank[0];
            end
            2'd2: begin
                n_y0 = s1_ybank[2]; n_y1 = s1_ybank[3];
                n_y2 = s1_ybank[0]; n_y3 = s1_ybank[1];
            end
            default: begin
                n_y0 = s1_ybank[3]; n_y1 = s1_ybank[0];
                n_y2 = s1_ybank[1]; n_y3 = s1_ybank[2];
            end
        endcase
    end

    assign n_e0 = AW'(n_y0);
    assign n_e1 = AW'(n_y1);
    assign n_e2 = AW'(n_y2);
    assign n_e3 = AW'(n_y3);

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_y1 <= n_e1;
            r_s2_c1 <= n_e2 - n_e0;
            r_s2_c2 <= (n_e0 <<< 1) - (n_e1 <<< 2) - n_e1 + (n_e2 <<< 2) - n_e3;
            r_s2_c3 <= (n_e3 - n_e0) + ((n_e1 - n_e2) <<< 1) + (n_e1 - n_e2);
            r_s2_f  <= r_s1_f;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: each product is floored by the arithmetic shift.
    // ------------------------------------------------------------------
    assign n_p3 = PW'(r_s2_c3) * PW'($signed({1'b0, r_s2_f}));

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_y1  <= r_s2_y1;
            r_s3_c1  <= r_s2_c1;
            r_s3_acc <= AW'(n_p3 >>> FRAC_BITS) + r_s2_c2;
            r_s3_f   <= r_s2_f;
        end
    end

    assign n_p4 = PW'(r_s3_acc) * PW'($signed({1'b0, r_s3_f}));

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_y1  <= r_s3_y1;
            r_s4_acc <= AW'(n_p4 >>> FRAC_BITS) + r_s3_c1;
            r_s4_f   <= r_s3_f;
        end
    end

    assign n_p5   = PW'(r_s4_acc) * PW'($signed({1'b0, r_s4_f}));
    assign n_acc5 = AW'(n_p5 >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s5_total <= (r_s4_y1 <<< 1) + n_acc5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: the total carries SAMPLE_BITS fraction bits; bring it to Q1.15.
    // ------------------------------------------------------------------
    assign n_ext = SW'(r_s5_total);

    generate
        if (SHIFT > 0) begin : g_scale_down
            localparam logic signed [SW-1:0] RND = SW'(1) << (SHIFT - 1);
            assign n_wide = (n_ext + RND) >>> SHIFT;
        end else if (SHIFT < 0) begin : g_scale_up
            assign n_wide = n_ext <<< (-SHIFT);
        end else begin : g_scale_none
            assign n_wide = n_ext;
        end
    endgenerate

    always_comb begin
        priority if (n_wide > SAT_HI) begin
            n_out = Q15_MAX;
        end else if (n_wide < SAT_LO) begin
            n_out = -Q15_MAX;
        end else begin
            n_out = n_wide[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s6_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stci_checker.sv =====
// ----------------------------------------------------------------------------
// stci_checker
// Port-level checks for the interpolated sine core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stci_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_ready,
    input wire logic                                 o_valid,
    input wire logic                                 i_ready,
    input wire logic signed [stci_pkg::OUT_BITS-1:0] o_sine_value
);

    import stci_pkg::*;

    // Saturation is symmetric, so the most negative code never appears.
    `ASSERT_IMPL(a_no_min_code, i_clk, i_rst_n, o_valid, o_sine_value >= -Q15_MAX)

    // A held result keeps its value until the sink takes it.
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sine_value))

    // A free output stage lets every stage advance, so requests are taken.
    `ASSERT_IMPL(a_ready_when_drained, i_clk, i_rst_n, i_ready || !o_valid, o_ready)

    // Reset empties the pipeline.
    `ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid)

endmodule

bind sine_table_cubic_interp_core stci_checker u_stci_checker (.*);

`default_nettype wire

// ===== tb/sine_table_checker.sv =====
// ----------------------------------------------------------------------------
// sine_table_checker
// Watches the phase and sine channels of the interpolated sine core. It
// predicts each sine value from its own copy of the sine table and compares
// it with the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sine_table_checker #(
    parameter int TABLE_BITS  = 12,
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_phase_valid,
    input  logic                                   i_phase_ready,
    input  logic [PHASE_BITS-1:0]                  i_phase_turn,
    input  logic                                   i_sine_valid,
    input  logic                                   i_sine_ready,
    input  logic signed [stci_pkg::OUT_BITS-1:0]   i_sine_value,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int SEG_SHIFT  = PHASE_BITS - TABLE_BITS;
    localparam int FRAC_W     = stci_pkg::FRAC_BITS;
    localparam int OUT_SHIFT  = SAMPLE_BITS - stci_pkg::OUT_FRAC;

    typedef struct {
        logic [PHASE_BITS-1:0]                phase;
        logic signed [stci_pkg::OUT_BITS-1:0] sine;
    } t_sine_request;

    longint        sine_samples [TABLE_SIZE];
    t_sine_request expected_sines [$];

    function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
        return (a * b + stci_pkg::Q30_HALF) >> 30;
    endfunction

    // Table sample j: angle folded into the first quadrant, Taylor series in Q30,
    // then scaled to the sample width with the quadrant's sign.
    function automatic longint sine_sample_at(int unsigned j);
        longint unsigned quarter, quad, r, x, x2, term, d, s, v, maxv;
        longint          acc_sum;
        int              n;
        quarter = TABLE_SIZE / 4;
        quad    = (j / quarter) & 3;
        r       = j % quarter;
        if (quad[0]) begin
            r = quarter - r;
        end
        x       = (stci_pkg::HALF_PI_Q30 * r + quarter / 2) / quarter;
        x2      = q30_product(x, x);
        term    = x;
        acc_sum = $signed(x);
        for (n = 1; n < stci_pkg::TAYLOR_TERMS; n++) begin
            d    = (2 * n) * (2 * n + 1);
            term = (q30_product(term, x2) + d / 2) / d;
            if (n % 2 == 1) begin
                acc_sum = acc_sum - $signed(term);
            end else begin
                acc_sum = acc_sum + $signed(term);
            end
        end
        if (acc_sum < 0) begin
            acc_sum = 0;
        end
        s = acc_sum;
        if (s > stci_pkg::Q30_ONE) begin
            s = stci_pkg::Q30_ONE;
        end
        maxv = (64'd1 << (SAMPLE_BITS - 1)) - 1;
        v    = (s * (64'd1 << (SAMPLE_BITS - 1)) + stci_pkg::Q30_HALF) >> 30;
        if (v > maxv) begin
            v = maxv;
        end
        return (quad >= 2) ? -$signed(v) : $signed(v);
    endfunction

    // One Horner step: acc * f / 2^FRAC_W, rounded toward minus infinity.
    function automatic longint horner_step(longint acc, longint unsigned frac);
        return (acc * $signed(frac)) >>> FRAC_W;
    endfunction

    function automatic logic signed [stci_pkg::OUT_BITS-1:0] predict_sine(
        logic [PHASE_BITS-1:0] phase
    );
        int unsigned     seg;
        longint unsigned rem, frac;
        longint          y0, y1, y2, y3, c1, c2, c3, acc, total;
        seg = (phase >> SEG_SHIFT) & (TABLE_SIZE - 1);
        rem = phase & ((64'd1 << SEG_SHIFT) - 1);
        if (SEG_SHIFT >= FRAC_W) begin
            frac = rem >> (SEG_SHIFT - FRAC_W);
        end else begin
            frac = rem << (FRAC_W - SEG_SHIFT);
        end
        // The sample at the phase is y1; y0 is the one before it.
        y0 = sine_samples[(seg + TABLE_SIZE - 1) & (TABLE_SIZE - 1)];
        y1 = sine_samples[seg];
        y2 = sine_samples[(seg + 1) & (TABLE_SIZE - 1)];
        y3 = sine_samples[(seg + 2) & (TABLE_SIZE - 1)];
        c1 = y2 - y0;
        c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c3 = (y3 - y0) + 3 * (y1 - y2);
        acc   = horner_step(c3, frac) + c2;
        acc   = horner_step(acc, frac) + c1;
        acc   = horner_step(acc, frac);
        total = 2 * y1 + acc;
        if (OUT_SHIFT > 0) begin
            total = (total + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        end else if (OUT_SHIFT < 0) begin
            total = total <<< (-OUT_SHIFT);
        end
        if (total > longint'(stci_pkg::Q15_MAX)) begin
            total = longint'(stci_pkg::Q15_MAX);
        end
        if (total < -longint'(stci_pkg::Q15_MAX)) begin
            total = -longint'(stci_pkg::Q15_MAX);
        end
        return total[stci_pkg::OUT_BITS-1:0];
    endfunction

    initial begin
        for (int k = 0; k < TABLE_SIZE; k++) begin
            sine_samples[k] = sine_sample_at(k);
        end
    end

    always @(posedge i_clk) begin
        t_sine_request oldest, incoming;
        int            taken, accepted;
        taken    = 0;
        accepted = 0;
        if (i_rst_n) begin
            // Retire first so a result can never match a request of the same cycle.
            if (i_sine_valid && i_sine_ready) begin
                if (expected_sines.size() == 0) begin
                    $error("sine_value with no request outstanding: got %0d", i_sine_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    oldest = expected_sines.pop_front();
                    taken  = 1;
                    if (i_sine_value !== oldest.sine) begin
                        $error("sine_value mismatch for phase 0x%h: expected %0d, got %0d",
                               oldest.phase, oldest.sine, i_sine_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_phase_valid && i_phase_ready) begin
                incoming.phase = i_phase_turn;
                incoming.sine  = predict_sine(i_phase_turn);
                expected_sines.push_back(incoming);
                accepted = 1;
            end
            o_pending <= o_pending + accepted - taken;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives phase requests into the interpolated sine core with random gaps on
// both channels and two long output stalls, then reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int TABLE_BITS   = 12;
    localparam int PHASE_BITS   = 32;
    localparam int SAMPLE_BITS  = 16;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_CYCLES = 80;
    localparam int SEG_SHIFT    = PHASE_BITS - TABLE_BITS;

    logic                                 i_clk        = 1'b0;
    logic                                 i_rst_n      = 1'b0;
    logic                                 i_valid      = 1'b0;
    logic                                 i_ready      = 1'b0;
    logic [PHASE_BITS-1:0]                i_phase_turn = '0;
    logic                                 o_ready;
    logic                                 o_valid;
    logic signed [stci_pkg::OUT_BITS-1:0] o_sine_value;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int requests_sent  = 0;
    int results_taken  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sine_table_cubic_interp_core #(
        .TABLE_BITS  (TABLE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_phase_turn (i_phase_turn),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sine_value (o_sine_value)
    );

    sine_table_checker #(
        .TABLE_BITS  (TABLE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_valid (i_valid),
        .i_phase_ready (o_ready),
        .i_phase_turn  (i_phase_turn),
        .i_sine_valid  (o_valid),
        .i_sine_ready  (i_ready),
        .i_sine_value  (o_sine_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Every fourth block of 64 runs back to back on that side.
    function automatic int idle_cycles(int index);
        if ((index / 64) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [PHASE_BITS-1:0] phase_at(int seg, logic [SEG_SHIFT-1:0] frac);
        return {seg[TABLE_BITS-1:0], frac};
    endfunction

    task automatic send_phase(input logic [PHASE_BITS-1:0] phase);
        int gap;
        gap = idle_cycles(requests_sent);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_phase_turn <= phase;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
    endtask

    function automatic logic [PHASE_BITS-1:0] random_phase();
        int seg;
        case ($urandom_range(0, 9))
            0: return phase_at($urandom_range(0, (1 << TABLE_BITS) - 1), '0);
            1: return phase_at($urandom_range(0, (1 << TABLE_BITS) - 1), '1);
            2, 3: begin
                // Around the peaks, troughs and zero crossings, where the
                // cubic overshoots and the table wraps.
                seg = (1 << (TABLE_BITS - 2)) * $urandom_range(0, 3)
                      + $urandom_range(0, 6) - 3;
                return phase_at(seg & ((1 << TABLE_BITS) - 1), SEG_SHIFT'($urandom));
            end
            default: return PHASE_BITS'($urandom);
        endcase
    endfunction

    initial begin
        logic [PHASE_BITS-1:0] directed_phases [$];
        directed_phases = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h8000_0000,
            32'hC000_0000, 32'h3FF0_0000, 32'h3FFF_FFFF, 32'h4000_8000,
            32'h4010_0000, 32'hBFFF_FFFF, 32'hC00F_FFFF, 32'h0000_000F,
            32'h0000_0010, 32'h000F_FFF0, 32'hFFF0_0000, 32'hFFF8_0000,
            32'h7FFF_FFFF, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h2468_ACE1
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_phases[n]) begin
            send_phase(directed_phases[n]);
        end
        repeat (RANDOM_ITEMS) begin
            send_phase(random_phase());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sine_table_cubic_interp_core test passed");
        end else begin
            $display("sine_table_cubic_interp_core test failed");
        end
        $finish;
    end

    // Output side: random stalls, plus two long hold-offs while requests keep
    // arriving so that the pipeline fills and the input backs up.
    initial begin
        int hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_taken == 100 || results_taken == 350) begin
                hold = STALL_CYCLES;
            end else begin
                hold = idle_cycles(results_taken);
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sine_table_cubic_interp_core test failed");
            $finish;
        end
    end

endmodule
